// ===== rtl/cdd_pkg.sv =====
`timescale 1ns / 1ps

package cdd_pkg;

    // field widths
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int DNUM_W  = 23;
    localparam int DIFF_W  = 23;

    // largest year accepted as valid
    localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(9999);

    // division by 100 as multiply by reciprocal, exact for all 14-bit values
    localparam int RECIP_W     = 13;
    localparam int PROD_W      = YEAR_W + RECIP_W;
    localparam int RECIP_SHIFT = 19;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);
    localparam logic [QUOT_W-1:0]  CENTURY   = QUOT_W'(100);

    // month codes
    localparam logic [MONTH_W-1:0] JANUARY  = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] FEBRUARY = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] DECEMBER = MONTH_W'(12);

    localparam logic [DAY_W-1:0] LEAP_FEB_LEN = DAY_W'(29);
    localparam logic [8:0]       DAYS_IN_YEAR = 9'd365;

    // month lengths of a common year, January first
    localparam logic [DAY_W-1:0] MONTH_LEN [12] =
        '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
          5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

    // days before the first of each month in a common year
    localparam logic [8:0] CUM_DAYS [12] =
        '{9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
          9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};

    typedef struct packed {
        logic [DAY_W-1:0]   first_day;
        logic [MONTH_W-1:0] first_month;
        logic [YEAR_W-1:0]  first_year;
        logic [DAY_W-1:0]   second_day;
        logic [MONTH_W-1:0] second_month;
        logic [YEAR_W-1:0]  second_year;
    } t_operands;

    typedef struct packed {
        logic signed [DIFF_W-1:0] day_difference;
        logic                     first_valid;
        logic                     second_valid;
    } t_result;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } t_date;

    // what one lane hands to the merge stage
    typedef struct packed {
        logic [DNUM_W-1:0] day_num;
        logic              valid;
    } t_lane_res;

endpackage

// ===== rtl/cdd_lane.sv =====
`timescale 1ns / 1ps

module cdd_lane
    import cdd_pkg::*;
(
    input  logic      i_clk,
    input  t_date     i_date,
    output t_lane_res o_res
);

    // stage 1: quotients by 100 of the year and of the year before
    logic [YEAR_W-1:0] prev_year;
    logic [PROD_W-1:0] prod_y;
    logic [PROD_W-1:0] prod_p;

    t_date             r_date;
    logic [QUOT_W-1:0] r_q_year;
    logic [QUOT_W-1:0] r_q_prev;

    assign prev_year = i_date.year - YEAR_W'(1);
    assign prod_y    = PROD_W'(i_date.year) * PROD_W'(RECIP_100);
    assign prod_p    = PROD_W'(prev_year) * PROD_W'(RECIP_100);

    always_ff @(posedge i_clk) begin
        r_date   <= i_date;
        r_q_year <= prod_y[PROD_W-1:RECIP_SHIFT];
        r_q_prev <= prod_p[PROD_W-1:RECIP_SHIFT];
    end

    // stage 2: leap rule, validity and day number
    logic [YEAR_W-1:0]  p;
    logic               div_by_100;
    logic               leap;
    logic               month_ok;
    logic [3:0]         idx;
    logic [DAY_W-1:0]   mlen;
    logic [DNUM_W-1:0]  base;
    logic [DNUM_W-1:0]  in_year;
    t_lane_res          n_res;
    t_lane_res          r_res;

    assign p          = r_date.year - YEAR_W'(1);
    assign div_by_100 = (r_date.year == YEAR_W'(r_q_year) * YEAR_W'(CENTURY));
    assign leap       = (r_date.year[1:0] == 2'b00 && !div_by_100) ||
                        (div_by_100 && r_q_year[1:0] == 2'b00);
    assign month_ok   = (r_date.month >= JANUARY) && (r_date.month <= DECEMBER);
    assign idx        = month_ok ? (r_date.month - JANUARY) : 4'd0;

    always_comb begin
        // length of the month, february stretched in leap years
        if (!month_ok) begin
            mlen = '0;
        end else if (r_date.month == FEBRUARY && leap) begin
            mlen = LEAP_FEB_LEN;
        end else begin
            mlen = MONTH_LEN[idx];
        end

        // days in whole years before this one, year zero counted as leap
        if (r_date.year == '0) begin
            base = '0;
        end else begin
            base = DNUM_W'(r_date.year) * DNUM_W'(DAYS_IN_YEAR)
                 + DNUM_W'(p >> 2) - DNUM_W'(r_q_prev)
                 + DNUM_W'(r_q_prev >> 2) + DNUM_W'(1);
        end

        in_year = DNUM_W'(CUM_DAYS[idx])
                + DNUM_W'(leap && (r_date.month > FEBRUARY))
                + DNUM_W'(r_date.day);

        n_res.day_num = base + in_year;
        n_res.valid   = (r_date.year <= YEAR_MAX) && month_ok &&
                        (r_date.day != '0) && (r_date.day <= mlen);
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

// ===== rtl/cdd_merge.sv =====
`timescale 1ns / 1ps

module cdd_merge
    import cdd_pkg::*;
(
    input  logic      i_clk,
    input  t_lane_res i_first,
    input  t_lane_res i_second,
    output t_result   o_result
);

    t_result n_result;
    t_result r_result;

    // difference only when both dates are real
    always_comb begin
        n_result.first_valid  = i_first.valid;
        n_result.second_valid = i_second.valid;
        if (i_first.valid && i_second.valid) begin
            n_result.day_difference = DIFF_W'(i_second.day_num - i_first.day_num);
        end else begin
            n_result.day_difference = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_result = r_result;

endmodule

// ===== rtl/calendar_date_difference.sv =====
`timescale 1ns / 1ps
// a result strobes out once its transaction has passed both lane stages and the merge register
// throughput: one transaction per cycle, the two dates run in separate lanes
// busy is never raised: every stage advances each cycle, the receiver cannot stall
// reset (synchronous, active low) clears the strobe pipeline; data registers keep values

module calendar_date_difference
    import cdd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_operands i_operands,
    output logic      o_strobe,
    output t_result   o_result
);

    t_date     first_date;
    t_date     second_date;
    t_lane_res first_res;
    t_lane_res second_res;
    logic      accept;
    logic [2:0] r_vld;
    logic [2:0] n_vld;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // split the transaction into one date per lane
    assign first_date.day     = i_operands.first_day;
    assign first_date.month   = i_operands.first_month;
    assign first_date.year    = i_operands.first_year;
    assign second_date.day    = i_operands.second_day;
    assign second_date.month  = i_operands.second_month;
    assign second_date.year   = i_operands.second_year;

    cdd_lane u_lane_first (
        .i_clk  (i_clk),
        .i_date (first_date),
        .o_res  (first_res)
    );

    cdd_lane u_lane_second (
        .i_clk  (i_clk),
        .i_date (second_date),
        .o_res  (second_res)
    );

    cdd_merge u_merge (
        .i_clk    (i_clk),
        .i_first  (first_res),
        .i_second (second_res),
        .o_result (o_result)
    );

    // strobe pipeline alongside the data stages
    assign n_vld = {r_vld[1:0], accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_strobe = r_vld[2];

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##3 o_strobe)
        else $error("result strobe missing three cycles after a transaction");

    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, 3))
        else $error("result strobe without a transaction");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !(o_result.first_valid && o_result.second_valid))
            |-> (o_result.day_difference == '0))
        else $error("nonzero difference for an invalid date");

    a_same_date_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_operands.first_day == i_operands.second_day
                && i_operands.first_month == i_operands.second_month
                && i_operands.first_year == i_operands.second_year)
            |-> ##3 (o_result.day_difference == '0))
        else $error("identical dates gave a nonzero difference");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

import cdd_pkg::*;

// predicts the day difference of each accepted date pair and checks the results in order
class day_count_scoreboard;
    t_result     pending_results[$];
    int unsigned mismatches;

    // month lengths of a common year, January first
    int unsigned common_len[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    function new();
        mismatches = 0;
    endfunction

    function bit leap_year(int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function int unsigned month_days(int unsigned m, int unsigned y);
        if (m < JANUARY || m > DECEMBER) begin
            return 0;
        end
        if (m == FEBRUARY && leap_year(y)) begin
            return 29;
        end
        return common_len[m - 1];
    endfunction

    function bit real_date(int unsigned d, int unsigned m, int unsigned y);
        if (y > YEAR_MAX) begin
            return 1'b0;
        end
        return d >= 1 && d <= month_days(m, y);
    endfunction

    // 1 January of year 0 is day 1
    function longint ordinal_day(int unsigned d, int unsigned m, int unsigned y);
        longint      n;
        int unsigned p;
        n = 0;
        if (y > 0) begin
            p = y - 1;
            n = 365 * longint'(y) + p / 4 - p / 100 + p / 400 + 1;
        end
        for (int unsigned k = JANUARY; k < m; k++) begin
            n += month_days(k, y);
        end
        return n + d;
    endfunction

    function t_result predict_difference(t_operands op);
        t_result r;
        longint  diff;
        r.first_valid  = real_date(op.first_day, op.first_month, op.first_year);
        r.second_valid = real_date(op.second_day, op.second_month, op.second_year);
        diff = 0;
        if (r.first_valid && r.second_valid) begin
            diff = ordinal_day(op.second_day, op.second_month, op.second_year)
                 - ordinal_day(op.first_day, op.first_month, op.first_year);
        end
        r.day_difference = diff[DIFF_W-1:0];
        return r;
    endfunction

    function void note_dates(t_operands op);
        pending_results.push_back(predict_difference(op));
    endfunction

    function void report(string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endfunction

    function void check_difference(t_result got);
        t_result want;
        if (pending_results.size() == 0) begin
            report($sformatf("unexpected result diff=%0d v1=%0b v2=%0b",
                             got.day_difference, got.first_valid, got.second_valid));
            return;
        end
        want = pending_results.pop_front();
        if (got.day_difference !== want.day_difference) begin
            report($sformatf("day_difference expected %0d actual %0d",
                             want.day_difference, got.day_difference));
        end
        if (got.first_valid !== want.first_valid) begin
            report($sformatf("first_valid expected %0b actual %0b",
                             want.first_valid, got.first_valid));
        end
        if (got.second_valid !== want.second_valid) begin
            report($sformatf("second_valid expected %0b actual %0b",
                             want.second_valid, got.second_valid));
        end
    endfunction

    function int unsigned outstanding();
        return pending_results.size();
    endfunction
endclass

module tb;

    localparam int RANDOM_PAIRS = 1250;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_operands i_operands;
    logic      o_strobe;
    t_result   o_result;

    day_count_scoreboard board = new();
    int unsigned         quiet_cycles = 0;

    calendar_date_difference dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_operands (i_operands),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    always #10 i_clk = ~i_clk;

    // note every accepted transaction and check every strobed result
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            board.note_dates(i_operands);
        end
        if (i_rst_n && o_strobe) begin
            board.check_difference(o_result);
        end
    end

    // watchdog on cycles with no transaction in either direction
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic t_operands date_pair(int unsigned d1, int unsigned m1, int unsigned y1,
                                            int unsigned d2, int unsigned m2, int unsigned y2);
        t_operands op;
        op.first_day    = d1[DAY_W-1:0];
        op.first_month  = m1[MONTH_W-1:0];
        op.first_year   = y1[YEAR_W-1:0];
        op.second_day   = d2[DAY_W-1:0];
        op.second_month = m2[MONTH_W-1:0];
        op.second_year  = y2[YEAR_W-1:0];
        return op;
    endfunction

    // years around the leap rule edges turn up often
    function automatic int unsigned pick_year();
        int unsigned edges[10] = '{0, 1, 99, 100, 399, 400, 1900, 2000, 9998, 9999};
        if ($urandom_range(0, 4) == 0) begin
            return edges[$urandom_range(0, 9)];
        end
        return $urandom_range(0, YEAR_MAX);
    endfunction

    function automatic t_operands random_pair();
        t_operands   op;
        int unsigned kind;
        int unsigned y1, y2, m1, m2;
        kind = $urandom_range(0, 99);
        op   = t_operands'({$urandom, $urandom});
        y1 = pick_year();
        m1 = $urandom_range(JANUARY, DECEMBER);
        y2 = pick_year();
        m2 = $urandom_range(JANUARY, DECEMBER);
        // dates close together: same or adjacent year
        if (kind >= 70 && kind < 80) begin
            y2 = (y1 == YEAR_MAX) ? y1 : y1 + $urandom_range(0, 1);
        end
        if (kind < 90) begin
            op.first_day    = DAY_W'($urandom_range(1, board.month_days(m1, y1)));
            op.first_month  = MONTH_W'(m1);
            op.first_year   = YEAR_W'(y1);
            op.second_day   = DAY_W'($urandom_range(1, board.month_days(m2, y2)));
            op.second_month = MONTH_W'(m2);
            op.second_year  = YEAR_W'(y2);
        end
        // one side replaced by raw noise
        if (kind >= 80 && kind < 90) begin
            if ($urandom_range(0, 1) == 0) begin
                op.first_day   = DAY_W'($urandom);
                op.first_month = MONTH_W'($urandom);
                op.first_year  = YEAR_W'($urandom);
            end else begin
                op.second_day   = DAY_W'($urandom);
                op.second_month = MONTH_W'($urandom);
                op.second_year  = YEAR_W'($urandom);
            end
        end
        return op;
    endfunction

    // idle for the given gap, then hold start until accepted
    task automatic send_pair(t_operands op, int unsigned gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) begin
                i_operands <= t_operands'({$urandom, $urandom});
                @(posedge i_clk);
            end
        end
        start      <= 1'b1;
        i_operands <= op;
        do begin
            @(posedge i_clk);
        end while (busy);
    endtask

    function automatic int unsigned pick_gap(int unsigned n);
        int unsigned r;
        if ((n / 40) % 4 == 1) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    initial begin
        t_operands directed[$];

        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_operands <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // widest span both ways, same date, leap rule corners
        directed.push_back(date_pair(1, 1, 0, 31, 12, 9999));
        directed.push_back(date_pair(31, 12, 9999, 1, 1, 0));
        directed.push_back(date_pair(15, 6, 2024, 15, 6, 2024));
        directed.push_back(date_pair(29, 2, 2000, 29, 2, 1900));
        directed.push_back(date_pair(29, 2, 2024, 29, 2, 2023));
        directed.push_back(date_pair(29, 2, 0, 1, 3, 0));
        directed.push_back(date_pair(28, 2, 1900, 1, 3, 1900));
        directed.push_back(date_pair(28, 2, 2100, 1, 3, 2100));
        directed.push_back(date_pair(31, 12, 0, 1, 1, 1));
        directed.push_back(date_pair(31, 12, 1999, 1, 1, 2000));
        // day out of range
        directed.push_back(date_pair(0, 1, 2000, 1, 1, 2000));
        directed.push_back(date_pair(31, 4, 2000, 31, 1, 2000));
        directed.push_back(date_pair(30, 2, 2000, 31, 12, 2000));
        // month out of range
        directed.push_back(date_pair(1, 0, 2000, 1, 13, 2000));
        directed.push_back(date_pair(1, 15, 2000, 10, 10, 1000));
        // year beyond the limit
        directed.push_back(date_pair(1, 1, 10000, 1, 1, 9999));
        directed.push_back(date_pair(1, 1, 9999, 1, 1, 16383));
        // all ones and all zeros
        directed.push_back(date_pair(31, 15, 16383, 31, 15, 16383));
        directed.push_back(date_pair(0, 0, 0, 0, 0, 0));
        directed.push_back(date_pair(31, 1, 0, 31, 12, 9999));

        foreach (directed[i]) begin
            send_pair(directed[i], (i % 3 == 2) ? 2 : 0);
        end
        for (int unsigned n = 0; n < RANDOM_PAIRS; n++) begin
            send_pair(random_pair(), pick_gap(n));
        end
        start <= 1'b0;

        // let the pipeline empty
        while (board.outstanding() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.mismatches == 0 && board.outstanding() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
